// ===== rtl/eta_pkg.sv =====
package eta_pkg;

    // lane geometry
    localparam int LANES     = 8;
    localparam int IDX_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int COST_W    = 64;
    localparam int CFG_W     = 4;
    localparam int DEPTH_W   = 4;

    // defaults for the top-level parameters
    localparam int DEF_MAX_TRACKS = 8;
    localparam int DEF_VALUE_BITS = 32;

    // register reset value and the clamp floor of the track count
    localparam logic [CFG_W-1:0] CNT_RESET = 4'd8;
    localparam logic [CFG_W-1:0] CNT_MIN   = 4'd2;

    typedef logic [LANES-1:0][VALUE_W-1:0] lanes_t;
    typedef logic [LANES-1:0][IDX_W-1:0]   order_t;
    typedef logic [COST_W-1:0]             cost_t;

endpackage

// ===== rtl/eta_square.sv =====
// Registered saturating square of a signed difference.
module eta_square #(
    parameter int DIFF_W = 35
) (
    input  logic                      clk,
    input  logic signed [DIFF_W-1:0]  diff,
    output eta_pkg::cost_t            square
);

    logic [DIFF_W-1:0] mag;
    logic              sat;

    // take the magnitude and flag anything of 2^32 or more
    always_comb
    begin
        mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        sat = |mag[DIFF_W-1:32];
    end

    // register the product
    always_ff @(posedge clk)
    begin
        if (sat)
        begin
            square <= '1;
        end
        else
        begin
            square <= eta_pkg::cost_t'(mag[31:0]) * eta_pkg::cost_t'(mag[31:0]);
        end
    end

endmodule

// ===== rtl/eta_search.sv =====
// Depth-first branch-and-bound search over candidate-to-track assignments.
module eta_search #(
    parameter int PRED_W = 34
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [eta_pkg::DEPTH_W-1:0]            n,
    input  eta_pkg::lanes_t                        cand,
    input  logic [eta_pkg::LANES-1:0][PRED_W-1:0]  pred,
    output logic                                   done,
    output eta_pkg::order_t                        chosen
);

    localparam int DIFF_W = PRED_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENTER,
        S_SCAN,
        S_MUL,
        S_ADD,
        S_POP
    } state_t;

    state_t                             state_reg;
    logic [eta_pkg::DEPTH_W-1:0]        d_reg;
    logic [eta_pkg::DEPTH_W-1:0]        c_reg;
    logic [eta_pkg::DEPTH_W-1:0]        n_reg;
    logic [eta_pkg::LANES-1:0]          taken_reg;
    eta_pkg::order_t                    trial_reg;
    eta_pkg::order_t                    chosen_reg;
    eta_pkg::cost_t                     cost_stk_reg [eta_pkg::LANES+1];
    eta_pkg::cost_t                     best_reg;
    logic                               have_reg;
    logic                               done_reg;
    logic signed [DIFF_W-1:0]           diff_reg;

    eta_pkg::cost_t                     square;
    eta_pkg::cost_t                     cur_cost;
    logic [eta_pkg::COST_W:0]           sum;
    logic [eta_pkg::DEPTH_W-1:0]        dm1;
    logic [eta_pkg::VALUE_W-1:0]        cand_sel;
    logic [PRED_W-1:0]                  pred_sel;
    logic [eta_pkg::IDX_W-1:0]          back_idx;

    eta_square #(
        .DIFF_W (DIFF_W)
    ) u_square (
        .clk    (clk),
        .diff   (diff_reg),
        .square (square)
    );

    // operand selection, saturating cost add, backtrack index
    always_comb
    begin
        cur_cost = cost_stk_reg[d_reg];
        sum      = {1'b0, cur_cost} + {1'b0, square};
        dm1      = d_reg - 4'd1;
        cand_sel = cand[c_reg[eta_pkg::IDX_W-1:0]];
        pred_sel = pred[d_reg[eta_pkg::IDX_W-1:0]];
        back_idx = trial_reg[dm1[eta_pkg::IDX_W-1:0]];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            have_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        d_reg           <= '0;
                        n_reg           <= n;
                        taken_reg       <= '0;
                        have_reg        <= 1'b0;
                        cost_stk_reg[0] <= '0;
                        for (int b = 0; b < eta_pkg::LANES; b++)
                        begin
                            chosen_reg[b] <= eta_pkg::IDX_W'(b);
                            trial_reg[b]  <= eta_pkg::IDX_W'(b);
                        end
                        state_reg <= S_ENTER;
                    end
                end
                S_ENTER:
                begin
                    // prune, record a full assignment, or open the level
                    if (have_reg && (cur_cost >= best_reg))
                    begin
                        state_reg <= S_POP;
                    end
                    else if (d_reg == n_reg)
                    begin
                        best_reg   <= cur_cost;
                        have_reg   <= 1'b1;
                        chosen_reg <= trial_reg;
                        state_reg  <= S_POP;
                    end
                    else
                    begin
                        c_reg     <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (c_reg == n_reg)
                    begin
                        state_reg <= S_POP;
                    end
                    else if (taken_reg[c_reg[eta_pkg::IDX_W-1:0]])
                    begin
                        c_reg <= c_reg + 4'd1;
                    end
                    else
                    begin
                        taken_reg[c_reg[eta_pkg::IDX_W-1:0]]   <= 1'b1;
                        trial_reg[d_reg[eta_pkg::IDX_W-1:0]]   <= c_reg[eta_pkg::IDX_W-1:0];
                        diff_reg <= $signed({{(DIFF_W-eta_pkg::VALUE_W){cand_sel[31]}},
                                             cand_sel})
                                  - $signed({pred_sel[PRED_W-1], pred_sel});
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    // descend with the accumulated cost
                    cost_stk_reg[d_reg + 4'd1] <= sum[eta_pkg::COST_W] ? '1
                                                : sum[eta_pkg::COST_W-1:0];
                    d_reg     <= d_reg + 4'd1;
                    state_reg <= S_ENTER;
                end
                S_POP:
                begin
                    if (d_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        d_reg               <= dm1;
                        c_reg               <= {1'b0, back_idx} + 4'd1;
                        taken_reg[back_idx] <= 1'b0;
                        state_reg           <= S_SCAN;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign chosen = chosen_reg;

endmodule

// ===== rtl/extrapolated_track_assignment.sv =====
// Extrapolated track assignment.
// Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser: eight signed
// Q16.16 candidates in s_tdata, the sweep start flag in s_tuser. Result
// words leave on m_tvalid/m_tready/m_tdata, eight reordered track values.
// The track count is written on cfg_valid/cfg_ready/cfg_data, always ready,
// and must only be written while the block is idle.
// A start word skips the search; its result loads when the output frees.
// Any other word runs a depth-first branch-and-bound search on one shared
// square unit: each tree node takes a difference, square, add and bound
// check step, with a further step for each candidate skipped or exhausted
// and each backtrack plus hand-over around the search, so latency depends on
// pruning and is bounded by the assignment tree for the track count in use.
// s_tready is low from acceptance until the result is loaded into the output
// register; one finished word may wait there while the next is accepted.
// If the receiver stalls, a finished result holds inside the block until
// the output register frees. Reset clears the history of every lane to zero
// and sets the track count to eight.
module extrapolated_track_assignment #(
    parameter int MAX_TRACKS = eta_pkg::DEF_MAX_TRACKS,
    parameter int VALUE_BITS = eta_pkg::DEF_VALUE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [255:0]                   s_tdata,   // value_0 .. value_7
    input  logic                           s_tuser,   // sweep_start
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [255:0]                   m_tdata,   // track_0 .. track_7
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [eta_pkg::CFG_W-1:0]      cfg_data   // cand_count
);

    localparam int PRED_W = (VALUE_BITS > 34) ? VALUE_BITS : 34;
    localparam logic [PRED_W-1:0] PRED_HI = {{(PRED_W-VALUE_BITS+1){1'b0}},
                                             {(VALUE_BITS-1){1'b1}}};
    localparam logic [PRED_W-1:0] PRED_LO = ~PRED_HI;
    localparam logic [eta_pkg::CFG_W-1:0] CNT_MAX = eta_pkg::CFG_W'(MAX_TRACKS);

    typedef enum logic [1:0] {
        T_IDLE,
        T_SEARCH,
        T_FINISH
    } state_t;

    state_t                                 state_reg;
    logic [eta_pkg::CFG_W-1:0]              count_reg;
    eta_pkg::lanes_t                        prev_reg;
    eta_pkg::lanes_t                        cur_reg;
    eta_pkg::lanes_t                        cand_reg;
    logic [eta_pkg::LANES-1:0][PRED_W-1:0]  pred_reg;
    logic                                   start_reg;
    logic [eta_pkg::CFG_W-1:0]              n_reg;
    logic                                   go_reg;
    logic                                   m_tvalid_reg;
    logic [255:0]                           m_tdata_reg;

    logic [eta_pkg::CFG_W-1:0]              n_clamp;
    logic [eta_pkg::LANES-1:0][PRED_W-1:0]  pred_calc;
    eta_pkg::lanes_t                        res;
    logic                                   srch_done;
    eta_pkg::order_t                        chosen;
    logic                                   accept;
    logic                                   out_free;

    eta_search #(
        .PRED_W (PRED_W)
    ) u_search (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (go_reg),
        .n      (n_reg),
        .cand   (cand_reg),
        .pred   (pred_reg),
        .done   (srch_done),
        .chosen (chosen)
    );

    // clamp the track count and form the saturated predictions
    always_comb
    begin
        if (count_reg < eta_pkg::CNT_MIN)
        begin
            n_clamp = eta_pkg::CNT_MIN;
        end
        else if (count_reg > CNT_MAX)
        begin
            n_clamp = CNT_MAX;
        end
        else
        begin
            n_clamp = count_reg;
        end
        for (int b = 0; b < eta_pkg::LANES; b++)
        begin
            logic signed [PRED_W-1:0] p;
            p = ($signed({{(PRED_W-32){cur_reg[b][31]}}, cur_reg[b]}) <<< 1)
              - $signed({{(PRED_W-32){prev_reg[b][31]}}, prev_reg[b]});
            if (p > $signed(PRED_HI))
            begin
                pred_calc[b] = PRED_HI;
            end
            else if (p < $signed(PRED_LO))
            begin
                pred_calc[b] = PRED_LO;
            end
            else
            begin
                pred_calc[b] = p;
            end
        end
    end

    // reorder the used lanes of a search word, pass the rest and start words through
    always_comb
    begin
        for (int b = 0; b < eta_pkg::LANES; b++)
        begin
            if (start_reg || (eta_pkg::CFG_W'(b) >= n_reg))
            begin
                res[b] = cand_reg[b];
            end
            else
            begin
                res[b] = cand_reg[chosen[b]];
            end
        end
    end

    assign accept    = s_tvalid && (state_reg == T_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == T_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // capture the word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cand_reg  <= s_tdata;
            pred_reg  <= pred_calc;
            start_reg <= s_tuser;
            n_reg     <= n_clamp;
        end
    end

    // control, history and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_IDLE;
            count_reg    <= eta_pkg::CNT_RESET;
            prev_reg     <= '0;
            cur_reg      <= '0;
            go_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            go_reg <= 1'b0;
            if (cfg_valid)
            begin
                count_reg <= cfg_data;
            end
            // drop the sent word unless a new one loads in its place
            if (m_tvalid_reg && m_tready && !((state_reg == T_FINISH) && out_free))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        if (s_tuser)
                        begin
                            state_reg <= T_FINISH;
                        end
                        else
                        begin
                            go_reg    <= 1'b1;
                            state_reg <= T_SEARCH;
                        end
                    end
                end
                T_SEARCH:
                begin
                    if (srch_done)
                    begin
                        state_reg <= T_FINISH;
                    end
                end
                T_FINISH:
                begin
                    // load the result once the output register frees
                    if (out_free)
                    begin
                        m_tdata_reg  <= res;
                        m_tvalid_reg <= 1'b1;
                        prev_reg     <= start_reg ? res : cur_reg;
                        cur_reg      <= res;
                        state_reg    <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

endmodule
